@@ hdl/mts_pkg.sv @@
// Shared constants and types for the minimum-tracking stack.
package mts_pkg;

	localparam int DEFAULT_STACK_DEPTH = 256;
	localparam int DEFAULT_VALUE_WIDTH = 32;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic push;
		logic pop;
	} mts_shift_t;

endpackage

@@ hdl/mts_cell.sv @@
// One stack cell holding an entry value and the running minimum at that depth.
module mts_cell import mts_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  mts_shift_t             shift,
	input  logic [VALUE_WIDTH-1:0] above_val,
	input  logic [VALUE_WIDTH-1:0] above_min,
	input  logic [VALUE_WIDTH-1:0] below_val,
	input  logic [VALUE_WIDTH-1:0] below_min,
	output logic [VALUE_WIDTH-1:0] val,
	output logic [VALUE_WIDTH-1:0] min
);

	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] min_q;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			val_q <= above_val;
			min_q <= above_min;
		end else if (shift.pop) begin
			val_q <= below_val;
			min_q <= below_min;
		end
	end

	assign val = val_q;
	assign min = min_q;

endmodule

@@ hdl/min_tracking_stack.sv @@
// Top level of the minimum-tracking stack built as a row of shifting cells.
//
// A last-in first-out stack whose every entry also carries the minimum of itself and all
// entries below it. Each input transaction is a push (s_tuser low) or a pop (s_tuser high)
// and yields exactly one output transaction reporting the popped value, the new top value,
// the current minimum, the entry count and a status (ok, underflow, overflow). The entries
// live in a row of STACK_DEPTH cells that all shift one place down on a push and one place
// up on a pop, so the top entry and its minimum always sit in the first cell. The block
// takes one transaction per clock cycle unless the output stalls; the result is registered
// and appears in the cycle after acceptance, and a new transaction is accepted while that
// result is being taken. An empty pop or a full push leaves the stack unchanged.
module min_tracking_stack import mts_pkg::*; #(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
	localparam int CountWidth = $clog2(STACK_DEPTH + 1),
	localparam int InDataWidth = ((VALUE_WIDTH + 7) / 8) * 8,
	localparam int OutDataWidth = ((3 * VALUE_WIDTH + CountWidth + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [InDataWidth-1:0]  s_tdata,  // value, zero padding
	input  logic                    s_tuser,  // mode
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OutDataWidth-1:0] m_tdata,  // popped_value, top_value, min_value,
	                                          // entry_count, zero padding
	output logic [1:0]              m_tuser   // status
);

	localparam logic [CountWidth-1:0] FullCount = CountWidth'(STACK_DEPTH);

	logic [CountWidth-1:0]  count_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] popped_q;
	logic [VALUE_WIDTH-1:0] top_q;
	logic [VALUE_WIDTH-1:0] min_out_q;
	logic [CountWidth-1:0]  count_out_q;
	logic [1:0]             status_q;

	logic [VALUE_WIDTH-1:0] cell_val [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] cell_min [STACK_DEPTH];

	logic                   accept;
	logic [VALUE_WIDTH-1:0] in_val;
	logic                   is_empty;
	logic                   is_full;
	logic                   do_push;
	logic                   do_pop;
	logic [VALUE_WIDTH-1:0] push_min;
	mts_shift_t             shift;

	logic [VALUE_WIDTH-1:0] nxt_popped;
	logic [VALUE_WIDTH-1:0] nxt_top;
	logic [VALUE_WIDTH-1:0] nxt_min;
	logic [CountWidth-1:0]  nxt_count;
	logic [1:0]             nxt_status;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign in_val   = s_tdata[VALUE_WIDTH-1:0];
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == FullCount);
	assign do_push  = accept && (s_tuser == MODE_PUSH) && !is_full;
	assign do_pop   = accept && (s_tuser == MODE_POP) && !is_empty;

	assign push_min = (!is_empty && ($signed(cell_min[0]) < $signed(in_val))) ?
		cell_min[0] : in_val;

	assign shift.push = do_push;
	assign shift.pop  = do_pop;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] up_val;
		logic [VALUE_WIDTH-1:0] up_min;
		logic [VALUE_WIDTH-1:0] dn_val;
		logic [VALUE_WIDTH-1:0] dn_min;

		if (i == 0) begin : g_first
			assign up_val = in_val;
			assign up_min = push_min;
		end else begin : g_inner_up
			assign up_val = cell_val[i-1];
			assign up_min = cell_min[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign dn_val = cell_val[i];
			assign dn_min = cell_min[i];
		end else begin : g_inner_dn
			assign dn_val = cell_val[i+1];
			assign dn_min = cell_min[i+1];
		end

		mts_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.shift    (shift),
			.above_val(up_val),
			.above_min(up_min),
			.below_val(dn_val),
			.below_min(dn_min),
			.val      (cell_val[i]),
			.min      (cell_min[i])
		);
	end

	always_comb begin
		nxt_popped = '0;
		nxt_top    = is_empty ? '0 : cell_val[0];
		nxt_min    = is_empty ? '0 : cell_min[0];
		nxt_count  = count_q;
		nxt_status = ST_OK;
		if (s_tuser == MODE_PUSH) begin
			if (is_full) begin
				nxt_status = ST_OVER;
			end else begin
				nxt_top   = in_val;
				nxt_min   = push_min;
				nxt_count = count_q + 1'b1;
			end
		end else begin
			if (is_empty) begin
				nxt_status = ST_UNDER;
			end else begin
				nxt_popped = cell_val[0];
				nxt_count  = count_q - 1'b1;
				if (count_q == CountWidth'(1)) begin
					nxt_top = '0;
					nxt_min = '0;
				end else begin
					nxt_top = cell_val[1];
					nxt_min = cell_min[1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= nxt_count;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q    <= nxt_popped;
			top_q       <= nxt_top;
			min_out_q   <= nxt_min;
			count_out_q <= nxt_count;
			status_q    <= nxt_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OutDataWidth'({count_out_q, min_out_q, top_q, popped_q});
	assign m_tuser  = status_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCount)
		else $error("entry count exceeds stack depth");

	a_pop_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> count_q == $past(count_q) - 1'b1)
		else $error("successful pop did not decrement the count");

	a_push_increments: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> count_q == $past(count_q) + 1'b1)
		else $error("successful push did not increment the count");

	a_over_reports_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == ST_OVER) |-> count_out_q == FullCount)
		else $error("overflow reported on a stack that is not full");

	a_under_reports_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == ST_UNDER) |->
		(count_out_q == '0 && top_q == '0 && min_out_q == '0 && popped_q == '0))
		else $error("underflow result does not describe an empty stack");

endmodule

@@ sim/min_tracking_stack_tb.sv @@
// Self-checking testbench for the minimum-tracking stack, with a shadow stack predicting every result.
module min_tracking_stack_tb;
	import mts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
	localparam int VW = DEFAULT_VALUE_WIDTH;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int OUT_W = ((3 * VW + CW + 7) / 8) * 8;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic [VW-1:0] popped;
		logic [VW-1:0] top;
		logic [VW-1:0] minimum;
		logic [CW-1:0] count;
		logic [1:0]    status;
	} stack_report_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [VW-1:0]    s_tdata;   // value
	logic             s_tuser;   // mode
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // popped_value, top_value, min_value, entry_count, padding
	logic [1:0]       m_tuser;   // status

	logic signed [VW-1:0] shadow_val [STACK_DEPTH];
	logic signed [VW-1:0] shadow_min [STACK_DEPTH];
	int                   shadow_depth;
	stack_report_t        pending_reports [$];
	int                   mismatches;
	bit                   idle_on;
	bit                   hold_req;

	min_tracking_stack dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("min_tracking_stack verification failed");
		$finish;
	end

	function automatic stack_report_t apply_stack_op(logic mode, logic signed [VW-1:0] value);
		stack_report_t r;
		r = '0;
		r.status = ST_OK;
		if (mode == MODE_PUSH) begin
			if (shadow_depth >= STACK_DEPTH) begin
				r.status = ST_OVER;
			end else begin
				shadow_val[shadow_depth] = value;
				if (shadow_depth > 0 && shadow_min[shadow_depth-1] < value)
					shadow_min[shadow_depth] = shadow_min[shadow_depth-1];
				else
					shadow_min[shadow_depth] = value;
				shadow_depth++;
			end
		end else if (shadow_depth == 0) begin
			r.status = ST_UNDER;
		end else begin
			shadow_depth--;
			r.popped = shadow_val[shadow_depth];
		end
		if (shadow_depth > 0) begin
			r.top = shadow_val[shadow_depth-1];
			r.minimum = shadow_min[shadow_depth-1];
		end
		r.count = shadow_depth[CW-1:0];
		return r;
	endfunction

	function automatic logic [VW-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(VW-1){1'b1}}};
			1: return {1'b1, {(VW-1){1'b0}}};
			2, 3, 4: return VW'($signed($urandom_range(0, 8)) - 4);
			default: return VW'($urandom);
		endcase
	endfunction

	task automatic send_op(input logic mode, input logic [VW-1:0] value);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		pending_reports.push_back(apply_stack_op(mode, value));
	endtask

	task automatic test_empty_pop();
		send_op(MODE_POP, '0);
		send_op(MODE_POP, VW'($urandom));
	endtask

	task automatic test_extremes();
		send_op(MODE_PUSH, {1'b0, {(VW-1){1'b1}}});
		send_op(MODE_PUSH, '0);
		send_op(MODE_PUSH, '0);
		send_op(MODE_PUSH, {1'b1, {(VW-1){1'b0}}});
		send_op(MODE_PUSH, '1);
		send_op(MODE_PUSH, VW'(1));
		repeat (6) send_op(MODE_POP, VW'($urandom));
		send_op(MODE_POP, '1);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (16) send_op($urandom_range(0, 3) == 0, pick_value());
	endtask

	task automatic test_full_stack();
		while (shadow_depth < STACK_DEPTH)
			send_op(MODE_PUSH, pick_value());
		send_op(MODE_PUSH, {1'b1, {(VW-1){1'b0}}});
		send_op(MODE_PUSH, VW'($urandom));
	endtask

	task automatic test_random_ops(input int count, input int push_pct);
		repeat (count)
			send_op($urandom_range(0, 99) >= push_pct, pick_value());
	endtask

	function automatic void check_field(string name, logic [VW-1:0] expected, logic [VW-1:0] actual);
		if (expected !== actual) begin
			$error("%s: expected %0d, got %0d", name, $signed(expected), $signed(actual));
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		stack_report_t got;
		stack_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[3*VW+CW-1:0], m_tuser};
			got.popped = m_tdata[VW-1:0];
			got.top = m_tdata[2*VW-1:VW];
			got.minimum = m_tdata[3*VW-1:2*VW];
			got.count = m_tdata[3*VW+CW-1:3*VW];
			got.status = m_tuser;
			if (pending_reports.size() == 0) begin
				$error("unexpected transaction on the output");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("popped_value", want.popped, got.popped);
				check_field("top_value", want.top, got.top);
				check_field("min_value", want.minimum, got.minimum);
				check_field("entry_count", VW'(want.count), VW'(got.count));
				check_field("status", VW'(want.status), VW'(got.status));
			end
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = MODE_PUSH;
		s_tdata = '0;
		shadow_depth = 0;
		mismatches = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_pop();
		test_extremes();
		test_backpressure();
		test_full_stack();
		test_random_ops(130, 25);
		test_random_ops(130, 55);
		idle_on = 1'b0;
		test_random_ops(110, 50);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("min_tracking_stack verification clean");
		else
			$display("min_tracking_stack verification failed");
		$finish;
	end

endmodule
